// ===== hdl/fp4bf_pkg.sv =====
// Shared types, constants and the element decode function for the FP4 to bf16 block.
package fp4bf_pkg;

  localparam logic [15:0] Bf16Zero  = 16'h0000;
  localparam logic [15:0] Bf16Qnan  = 16'h7FC0;
  localparam logic [15:0] Bf16Inf   = 16'h7F80;
  localparam logic [15:0] HalfPat   = 16'h3F00;
  localparam logic [7:0]  ScaleZero = 8'h00;
  localparam logic [7:0]  ScaleInf  = 8'hFF;

  typedef struct packed {
    logic [7:0] code_byte;
    logic [7:0] scale_byte;
  } in_item_t;

  typedef struct packed {
    logic [15:0] first_value;
    logic [15:0] second_value;
  } out_item_t;

  function automatic logic [15:0] decode_one(input logic [3:0] code, input logic [7:0] scale);
    logic [2:0]  mag;
    logic [15:0] pat;
    logic [9:0]  ex;
    logic [15:0] res;
    mag = code[2:0];
    pat = (mag == 3'd1) ? HalfPat : HalfPat + {7'd0, mag, 6'd0};
    ex  = {2'b00, pat[14:7]} + {2'b00, scale} - 10'd127;
    if (scale == ScaleZero) begin
      res = Bf16Zero;
    end else if (scale == ScaleInf) begin
      res = (mag == 3'd0) ? Bf16Qnan : ({code[3], 15'd0} | Bf16Inf);
    end else if (mag == 3'd0) begin
      res = Bf16Zero;
    end else if (ex[9] || ex == 10'd0) begin
      res = Bf16Zero;
    end else if (ex >= 10'd255) begin
      res = {code[3], 15'd0} | Bf16Inf;
    end else begin
      res = {code[3], ex[7:0], pat[6:0]};
    end
    return res;
  endfunction

endpackage

// ===== hdl/fp4bf_if.sv =====
// Valid/ready channel interfaces for input and result items.
interface fp4bf_in_if;
  logic                valid;
  logic                ready;
  fp4bf_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface fp4bf_out_if;
  logic                 valid;
  logic                 ready;
  fp4bf_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/fp4bf_decode.sv =====
// Combinational decode of one code pair with its block scale into two bf16 values.
module fp4bf_decode (
  input  fp4bf_pkg::in_item_t  item_i,
  output fp4bf_pkg::out_item_t result_o
);
  assign result_o.first_value  = fp4bf_pkg::decode_one(item_i.code_byte[3:0],
                                                       item_i.scale_byte);
  assign result_o.second_value = fp4bf_pkg::decode_one(item_i.code_byte[7:4],
                                                       item_i.scale_byte);
endmodule

// ===== hdl/fp4_block_scaled_to_bf16.sv =====
// Top level of the FP4 (E2M1) block-scaled to bf16 dequantizer.
// Each input item is one byte of two E2M1 codes plus the E8M0 scale byte of
// their block; each yields one result item of two bf16 values. An item is
// registered on entry, decoded by combinational logic and registered as a
// result, and one item is accepted every cycle while the output is taken.
// Subnormal results are flushed to zero.
module fp4_block_scaled_to_bf16 (
  input  logic        clk_i,
  input  logic        rst_ni,
  fp4bf_in_if.sink    in_i,
  fp4bf_out_if.source out_o
);
  logic                 in_vld_q, out_vld_q;
  fp4bf_pkg::in_item_t  in_q;
  fp4bf_pkg::out_item_t out_q, res_d;
  logic                 adv_out, adv_in;

  assign adv_out    = !out_vld_q || out_o.ready;
  assign adv_in     = !in_vld_q || adv_out;
  assign in_i.ready = adv_in;

  fp4bf_decode u_dec (.item_i(in_q), .result_o(res_d));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (adv_in) in_vld_q <= in_i.valid;
      if (adv_out) out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_in && in_i.valid) in_q <= in_i.data;
    if (adv_out && in_vld_q) out_q <= res_d;
  end

  assign out_o.valid = out_vld_q;
  assign out_o.data  = out_q;

`ifndef SYNTHESIS
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && !out_o.ready |=> out_vld_q && $stable(out_q))
    else $error("result lost while stalled");
  a_move: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_vld_q && adv_out |=> out_vld_q && out_q == $past(res_d))
    else $error("result not taken from decode");
  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_vld_q && !adv_out |-> !in_i.ready)
    else $error("input accepted over full pipeline");
`endif
endmodule
